/* rtl/swmb_pkg.sv */
// ---------------------------------------------------------------------------
// swmb_pkg
// Shared types and constants of the sector wall mesh builder.
// ---------------------------------------------------------------------------
`default_nettype none
package swmb_pkg;
	localparam int COORD_BITS_DEF   = 8;
	localparam int TEXTURE_BITS_DEF = 5;
	localparam int ADDR_BITS        = 5;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [2:0] REG_ORG_X = 3'd0;
	localparam logic [2:0] REG_ORG_Z = 3'd1;
	localparam logic [2:0] REG_EXT_X = 3'd2;
	localparam logic [2:0] REG_EXT_Z = 3'd3;
	localparam logic [2:0] REG_TOP   = 3'd4;
	localparam logic [2:0] REG_TEX   = 3'd5;
	localparam logic [2:0] REG_MAP_W = 3'd6;
	localparam logic [2:0] REG_MAP_D = 3'd7;

	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [2:0] FACE_FLAT = 3'd0;

	// one queued job: a flat face, or up to two wall quads
	typedef struct packed {
		logic       flat;
		logic       wall_a;     // first quad present
		logic       wall_b;     // second quad present
		logic [1:0] strip;
		logic [7:0] org_a;
		logic [7:0] len_a;
		logic [7:0] diff_a;
		logic [7:0] org_b;
		logic [7:0] diff_b;
		logic [7:0] tallest;    // value after the whole item
	} job_t;

	// per vertex: far end of run, bottom y; index [sel][k]
	function automatic logic wall_far(input logic sel, input logic [2:0] k);
		logic [5:0] t;
		t = sel ? 6'b110010 : 6'b011010;
		return t[k];
	endfunction

	function automatic logic wall_bot(input logic sel, input logic [2:0] k);
		logic [5:0] t;
		t = sel ? 6'b011001 : 6'b110100;
		return t[k];
	endfunction
endpackage
`default_nettype wire

/* rtl/swmb_front.sv */
// ---------------------------------------------------------------------------
// swmb_front
// Accepts items, tracks the open strip and run, and posts jobs to the queue.
// ---------------------------------------------------------------------------
`default_nettype none
module swmb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          opcode,
	input  wire logic [1:0]    strip_index,
	input  wire logic [7:0]    neighbor_height,
	input  wire logic [7:0]    org_x,
	input  wire logic [7:0]    org_z,
	input  wire logic [7:0]    ext_x,
	input  wire logic [7:0]    ext_z,
	input  wire logic [7:0]    top,
	input  wire logic [7:0]    map_w,
	input  wire logic [7:0]    map_d,
	output logic               job_valid,
	input  wire logic          job_full,
	output swmb_pkg::job_t     job
);
	import swmb_pkg::*;

	logic [7:0] run_origin_q, run_length_q, strip_position_q, tallest_q;
	logic [8:0] run_diff_q;
	logic [1:0] active_strip_q;

	logic       ew, side, skip, acc, newstrip, first, same, ends;
	logic [7:0] org_f, ext_f, msize, org_v, ext_v;
	logic [8:0] diff, osum;
	logic [8:0] pos1;
	logic [7:0] ro_n, rl_n;
	logic [8:0] rd_n;
	logic       ca, cb;
	logic [7:0] t1, t2;

	assign in_stall = job_full;
	assign acc = in_valid && !job_full;

	always_comb begin
		ew    = strip_index[1];
		side  = strip_index[0];
		org_f = ew ? org_z : org_x;
		ext_f = ew ? ext_z : ext_x;
		msize = ew ? map_d : map_w;
		org_v = ew ? org_x : org_z;
		ext_v = ew ? ext_x : ext_z;
		diff  = {1'b0, top} - {1'b0, neighbor_height};
		osum  = {1'b0, org_f} + {1'b0, ext_f};
		skip  = side ? (org_f == 8'd0) : (osum >= {1'b0, msize});
		newstrip = strip_index != active_strip_q;
		first = newstrip || strip_position_q == 8'd0;
		same  = diff == run_diff_q;
		pos1  = {1'b0, (first ? 8'd0 : strip_position_q)} + 9'd1;
		ends  = pos1 >= {1'b0, ext_v};
		// run broken by this sample
		ca = !first && !same && run_length_q != 8'd0 && !run_diff_q[8]
			&& run_diff_q != 9'd0;
		if (first) begin
			ro_n = org_v; rl_n = 8'd1; rd_n = diff;
		end else if (same) begin
			ro_n = run_origin_q; rl_n = run_length_q + 8'd1; rd_n = run_diff_q;
		end else begin
			ro_n = org_v + strip_position_q; rl_n = 8'd1; rd_n = diff;
		end
		cb = ends && !rd_n[8] && rd_n != 9'd0;
		t1 = (ca && run_diff_q[7:0] > tallest_q) ? run_diff_q[7:0] : tallest_q;
		t2 = (cb && rd_n[7:0] > t1) ? rd_n[7:0] : t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_origin_q <= '0; run_length_q <= '0; run_diff_q <= '0;
			strip_position_q <= '0; active_strip_q <= '0; tallest_q <= '0;
		end else if (acc) begin
			if (opcode == OP_START) begin
				tallest_q <= '0; strip_position_q <= '0; run_length_q <= '0;
				run_diff_q <= '0; run_origin_q <= '0;
			end else if (!skip) begin
				active_strip_q <= strip_index;
				run_origin_q   <= ro_n;
				run_diff_q     <= rd_n;
				tallest_q      <= t2;
				run_length_q   <= ends ? 8'd0 : rl_n;
				strip_position_q <= ends ? 8'd0 : pos1[7:0];
			end
		end
	end

	always_comb begin
		job.flat    = opcode == OP_START;
		job.wall_a  = opcode == OP_SAMPLE && !skip && ca;
		job.wall_b  = opcode == OP_SAMPLE && !skip && cb;
		job.strip   = strip_index;
		job.org_a   = ca ? run_origin_q : ro_n;
		job.len_a   = ca ? run_length_q : rl_n;
		job.diff_a  = ca ? run_diff_q[7:0] : rd_n[7:0];
		job.org_b   = ro_n;
		job.diff_b  = rd_n[7:0];
		job.tallest = (opcode == OP_START) ? 8'd0 : t2;
		// second quad is a one-sample run
		if (!ca) job.wall_a = job.wall_b && opcode == OP_SAMPLE && !skip;
		if (!ca) job.wall_b = 1'b0;
	end
	assign job_valid = acc && (job.flat || job.wall_a);
endmodule
`default_nettype wire

/* rtl/swmb_back.sv */
// ---------------------------------------------------------------------------
// swmb_back
// Job queue and vertex sequencer: one registered vertex per unstalled cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module swmb_back #(
	parameter int COORD_BITS   = swmb_pkg::COORD_BITS_DEF,
	parameter int TEXTURE_BITS = swmb_pkg::TEXTURE_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    job_valid,
	output logic                         job_full,
	input  wire swmb_pkg::job_t          job,
	input  wire logic [7:0]              org_x,
	input  wire logic [7:0]              org_z,
	input  wire logic [7:0]              ext_x,
	input  wire logic [7:0]              ext_z,
	input  wire logic [7:0]              top,
	input  wire logic [TEXTURE_BITS-1:0] tex,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [7:0]                   vert_x,
	output logic [7:0]                   vert_y,
	output logic [7:0]                   vert_z,
	output logic [7:0]                   face_attr,
	output logic                         last_vertex,
	output logic [7:0]                   biggest_height
);
	import swmb_pkg::*;

	localparam logic [COORD_BITS-1:0] CMASK = '1;

	job_t       q_mem [QUEUE_DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [2:0] k_q;
	logic       quad_q;   // 0 first group, 1 second
	job_t       h;
	logic       pop, adv, push;

	assign job_full = cnt_q == 2'(QUEUE_DEPTH);
	assign push = job_valid && !job_full;
	assign h = q_mem[rp_q];
	assign adv = cnt_q != 2'd0 && (!out_valid || !out_stall);

	logic       lastk, lastgrp;
	logic       ew, side, sel, far_s, bot_s;
	logic [7:0] fixed, o, l, d, nearv, farv, var_c, y, bot, fx, fz, cx, cy, cz;
	logic [2:0] id;

	function automatic logic [7:0] cm(input logic [7:0] v);
		return v & 8'(CMASK);
	endfunction

	always_comb begin
		lastk   = k_q == 3'd5;
		lastgrp = h.flat || !h.wall_b || quad_q;
		pop     = adv && lastk && lastgrp;
		ew   = h.strip[1];
		side = h.strip[0];
		sel  = side ^ ew;
		o = quad_q ? h.org_b : h.org_a;
		l = quad_q ? 8'd1 : h.len_a;
		d = quad_q ? h.diff_b : h.diff_a;
		if (ew) fixed = side ? org_z : org_z + ext_z;
		else    fixed = side ? org_x : org_x + ext_x;
		nearv = o;
		farv  = o + l;
		bot   = top - d;
		far_s = wall_far(sel, k_q);
		bot_s = wall_bot(sel, k_q);
		var_c = far_s ? farv : nearv;
		y     = bot_s ? bot : top;
		id    = 3'd1 + {2'b0, ew} + (side ? 3'd2 : 3'd0);
		fx = org_x + ext_x;
		fz = org_z + ext_z;
		if (h.flat) begin
			cy = top;
			case (k_q)
				3'd0: begin cx = org_x; cz = fz; end
				3'd1: begin cx = fx; cz = org_z; end
				3'd2: begin cx = org_x; cz = org_z; end
				3'd3: begin cx = org_x; cz = fz; end
				3'd4: begin cx = fx; cz = fz; end
				default: begin cx = fx; cz = org_z; end
			endcase
		end else begin
			cy = y;
			cx = ew ? var_c : fixed;
			cz = ew ? fixed : var_c;
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= job;
		if (adv) begin
			vert_x <= cm(cx);
			vert_y <= cy;
			vert_z <= cm(cz);
			face_attr <= {8'(tex) << 3} | {5'd0, h.flat ? FACE_FLAT : id};
			last_vertex <= lastk && lastgrp;
			biggest_height <= h.tallest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; k_q <= '0; quad_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (adv) begin
				out_valid <= 1'b1;
				if (lastk) begin
					k_q <= '0;
					quad_q <= lastgrp ? 1'b0 : 1'b1;
				end else k_q <= k_q + 3'd1;
			end else if (!out_stall) out_valid <= 1'b0;
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
	a_k: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= 3'd5) else $error("vertex index out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(vert_x) && $stable(last_vertex))
		else $error("output changed under stall");
endmodule
`default_nettype wire

/* rtl/sector_wall_mesh_builder_unit.sv */
// ---------------------------------------------------------------------------
// sector_wall_mesh_builder_unit
// Emits top face and wall quads of a heightmap sector as vertex words.
// ---------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in      | input     | in_valid/stall   | opcode, strip_index, neighbor_height
// out     | output    | out_valid/stall  | vert_xyz, face_attr, last, biggest
// cfg     | input     | APB write/read   | eight registers at 4*i
// Each quad or flat face is six vertices at one vertex per unstalled cycle;
// a sample closing two runs gives twelve. The vertex sequencer sets the rate.
// The front takes a word whenever the two-entry job queue has room.
// Reset clears queue, sequencer and run state; registers reset to defaults.
`default_nettype none
module sector_wall_mesh_builder_unit #(
	parameter int COORD_BITS   = swmb_pkg::COORD_BITS_DEF,
	parameter int TEXTURE_BITS = swmb_pkg::TEXTURE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [1:0]  strip_index,
	input  wire logic [7:0]  neighbor_height,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       vert_x,
	output logic [7:0]       vert_y,
	output logic [7:0]       vert_z,
	output logic [7:0]       face_attr,
	output logic             last_vertex,
	output logic [7:0]       biggest_height,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [swmb_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import swmb_pkg::*;

	logic [7:0] org_x_q, org_z_q, ext_x_q, ext_z_q, top_q, map_w_q, map_d_q;
	logic [TEXTURE_BITS-1:0] tex_q;
	logic [2:0] ridx;
	logic job_valid, job_full;
	job_t job;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0; org_z_q <= '0; ext_x_q <= 8'd1; ext_z_q <= 8'd1;
			top_q <= '0; tex_q <= '0; map_w_q <= 8'd255; map_d_q <= 8'd255;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			unique case (ridx)
				REG_ORG_X: org_x_q <= pwdata[7:0];
				REG_ORG_Z: org_z_q <= pwdata[7:0];
				REG_EXT_X: ext_x_q <= pwdata[7:0];
				REG_EXT_Z: ext_z_q <= pwdata[7:0];
				REG_TOP:   top_q   <= pwdata[7:0];
				REG_TEX:   tex_q   <= pwdata[TEXTURE_BITS-1:0];
				REG_MAP_W: map_w_q <= pwdata[7:0];
				REG_MAP_D: map_d_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_ORG_X: prdata = {24'd0, org_x_q};
			REG_ORG_Z: prdata = {24'd0, org_z_q};
			REG_EXT_X: prdata = {24'd0, ext_x_q};
			REG_EXT_Z: prdata = {24'd0, ext_z_q};
			REG_TOP:   prdata = {24'd0, top_q};
			REG_TEX:   prdata = 32'(tex_q);
			REG_MAP_W: prdata = {24'd0, map_w_q};
			default:   prdata = {24'd0, map_d_q};
		endcase
	end

	swmb_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .strip_index, .neighbor_height,
		.org_x(org_x_q), .org_z(org_z_q), .ext_x(ext_x_q), .ext_z(ext_z_q),
		.top(top_q), .map_w(map_w_q), .map_d(map_d_q),
		.job_valid, .job_full, .job
	);

	swmb_back #(.COORD_BITS(COORD_BITS), .TEXTURE_BITS(TEXTURE_BITS)) u_back (
		.clk, .arst_n, .job_valid, .job_full, .job,
		.org_x(org_x_q), .org_z(org_z_q), .ext_x(ext_x_q), .ext_z(ext_z_q),
		.top(top_q), .tex(tex_q),
		.out_valid, .out_stall, .vert_x, .vert_y, .vert_z, .face_attr,
		.last_vertex, .biggest_height
	);
endmodule
`default_nettype wire
